// ===== rtl/fnms_pkg.sv =====
`default_nettype none

package fnms_pkg;

  // field widths fixed by the stream format
  localparam int ROW_BITS       = 12;
  localparam int COL_BITS       = 6;
  localparam int NROWS_BITS     = 13;
  localparam int SMOOTH_BITS    = 16;
  localparam int OUT_TDATA_BITS = 40;
  localparam int ROWS_LIMIT     = 4096;

  // parameter defaults
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_COLS_DEF    = 62;
  localparam int QUEUE_DEPTH_DEF = 4;

  // configuration register indexes
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_ROWS = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_NUM_COLS = 1'b1;

  // slot of each neighbour value in a command's value vector
  localparam int VAL_UP    = 0;
  localparam int VAL_DOWN  = 1;
  localparam int VAL_LEFT  = 2;
  localparam int VAL_RIGHT = 3;
  localparam int NUM_NBRS  = 4;

  // which neighbours lie inside the matrix
  typedef struct packed {
    logic right;
    logic left;
    logic down;
    logic up;
  } nbr_t;

  // per-result control info travelling from front to back
  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    nbr_t                nbr;
    logic                run_last;
    logic                frame_last;
  } meta_t;

  localparam int META_BITS = $bits(meta_t);

  // last row index for a num_rows write, clamped to 2..4096 rows
  function automatic logic [ROW_BITS-1:0] rows_last(input logic [NROWS_BITS-1:0] v);
    logic [NROWS_BITS-1:0] m1;
    m1 = v - NROWS_BITS'(1);
    priority if (v < NROWS_BITS'(2)) begin
      rows_last = ROW_BITS'(1);
    end else if (v > NROWS_BITS'(ROWS_LIMIT)) begin
      rows_last = ROW_BITS'(ROWS_LIMIT - 1);
    end else begin
      rows_last = m1[ROW_BITS-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fnms_front.sv =====
`default_nettype none

module fnms_front #(
  parameter int SAMPLE_BITS = fnms_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_COLS    = fnms_pkg::MAX_COLS_DEF,
  parameter int DEPTH       = fnms_pkg::QUEUE_DEPTH_DEF,
  localparam int LW         = $clog2(DEPTH + 1)
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       restart,
  input  logic [fnms_pkg::ROW_BITS-1:0]              last_row,
  input  logic [fnms_pkg::COL_BITS-1:0]              last_col,
  input  logic                                       s_valid,
  output logic                                       s_ready,
  input  logic [SAMPLE_BITS-1:0]                     s_sample,
  input  logic [LW-1:0]                              q_level,
  output logic                                       cmd_push,
  output fnms_pkg::meta_t                            cmd_meta,
  output logic [fnms_pkg::NUM_NBRS*SAMPLE_BITS-1:0]  cmd_vals
);

  localparam int AW = $clog2(3 * MAX_COLS);
  localparam logic [AW-1:0] BASE1 = AW'(MAX_COLS);
  localparam logic [AW-1:0] BASE2 = AW'(2 * MAX_COLS);
  localparam int RB = fnms_pkg::ROW_BITS;
  localparam int CB = fnms_pkg::COL_BITS;

  function automatic logic [AW-1:0] slot_addr(input logic [1:0] bank,
                                              input logic [CB-1:0] c);
    logic [AW-1:0] base;
    unique case (bank)
      2'd1:    base = BASE1;
      2'd2:    base = BASE2;
      default: base = '0;
    endcase
    slot_addr = base + AW'(c);
  endfunction

  // three row banks, row r lives in bank r mod 3
  logic [SAMPLE_BITS-1:0] mem [3*MAX_COLS];

  logic [RB-1:0] row;
  logic [CB-1:0] col;
  logic [CB-1:0] dcol;
  logic [1:0]    bank_cur;
  logic [1:0]    bank_m1;
  logic [1:0]    bank_m2;
  logic          draining;

  logic          s1_valid;
  logic          s1_push;
  fnms_pkg::meta_t s1_meta;
  logic [SAMPLE_BITS-1:0] s1_down;
  logic [SAMPLE_BITS-1:0] rd_a;
  logic [SAMPLE_BITS-1:0] rd_b;
  logic [SAMPLE_BITS-1:0] hist1;
  logic [SAMPLE_BITS-1:0] hist2;

  logic          room;
  logic          acc;
  logic          issue;
  logic          row_last;
  logic          col_last;
  logic          dcol_last;
  logic          push;
  logic [AW-1:0] addr_w;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  fnms_pkg::meta_t cmd;

  always_comb begin
    room      = ({1'b0, q_level} + (LW+1)'(s1_valid)) < (LW+1)'(DEPTH);
    row_last  = (row == last_row);
    col_last  = (col == last_col);
    dcol_last = (dcol == last_col);
    s_ready   = !draining && room;
    acc       = s_valid && s_ready;
    issue     = acc || (draining && room);
    addr_w    = slot_addr(bank_cur, col);
    if (draining) begin
      // last row of the frame, one element per step
      addr_a         = slot_addr(bank_cur, dcol_last ? CB'(0) : dcol + CB'(1));
      addr_b         = slot_addr(bank_m1, dcol);
      cmd.row        = row;
      cmd.col        = dcol;
      cmd.nbr.up     = 1'b1;
      cmd.nbr.down   = 1'b0;
      cmd.nbr.left   = (dcol != CB'(0));
      cmd.nbr.right  = !dcol_last;
      cmd.run_last   = dcol_last;
      cmd.frame_last = dcol_last;
      push           = 1'b1;
    end else begin
      // sample (r,c) completes element (r-1,c); at end of row prefetch (r,0)
      addr_a         = col_last ? slot_addr(bank_cur, CB'(0))
                                : slot_addr(bank_m1, col + CB'(1));
      addr_b         = slot_addr(bank_m2, col);
      cmd.row        = row - RB'(1);
      cmd.col        = col;
      cmd.nbr.up     = (row > RB'(1));
      cmd.nbr.down   = 1'b1;
      cmd.nbr.left   = (col != CB'(0));
      cmd.nbr.right  = !col_last;
      cmd.run_last   = !(row_last && col_last);
      cmd.frame_last = 1'b0;
      push           = (row != RB'(0));
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      mem[addr_w] <= s_sample;
    end
    if (issue) begin
      rd_a    <= mem[addr_a];
      rd_b    <= mem[addr_b];
      s1_meta <= cmd;
      s1_down <= s_sample;
    end
    // left neighbour is the port A read of two commands back
    if (s1_valid) begin
      hist1 <= rd_a;
      hist2 <= hist1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row      <= '0;
      col      <= '0;
      dcol     <= '0;
      draining <= 1'b0;
      bank_cur <= 2'd0;
      bank_m1  <= 2'd2;
      bank_m2  <= 2'd1;
    end else if (acc) begin
      if (col_last) begin
        col <= '0;
        if (row_last) begin
          draining <= 1'b1;
          dcol     <= '0;
        end else begin
          row      <= row + RB'(1);
          bank_m2  <= bank_m1;
          bank_m1  <= bank_cur;
          bank_cur <= (bank_cur == 2'd2) ? 2'd0 : bank_cur + 2'd1;
        end
      end else begin
        col <= col + CB'(1);
      end
    end else if (draining && room) begin
      if (dcol_last) begin
        draining <= 1'b0;
        row      <= '0;
        bank_cur <= 2'd0;
        bank_m1  <= 2'd2;
        bank_m2  <= 2'd1;
      end else begin
        dcol <= dcol + CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_push  <= 1'b0;
    end else begin
      s1_valid <= issue;
      s1_push  <= issue && push;
    end
  end

  assign cmd_push = s1_valid && s1_push;
  assign cmd_meta = s1_meta;
  assign cmd_vals = {rd_a, hist2, s1_down, rd_b};

endmodule

`default_nettype wire

// ===== rtl/fnms_queue.sv =====
`default_nettype none

module fnms_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = fnms_pkg::QUEUE_DEPTH_DEF,
  localparam int LW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] pop_data,
  output logic [LW-1:0]    level
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   level <= level + LW'(1);
        2'b01:   level <= level - LW'(1);
        default: level <= level;
      endcase
    end
  end

  assign valid    = (level != '0);
  assign pop_data = slots[rd_ptr];

endmodule

`default_nettype wire

// ===== rtl/fnms_back.sv =====
`default_nettype none

module fnms_back #(
  parameter int SAMPLE_BITS = fnms_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       q_valid,
  input  fnms_pkg::meta_t                            q_meta,
  input  logic [fnms_pkg::NUM_NBRS*SAMPLE_BITS-1:0]  q_vals,
  output logic                                       q_pop,
  output logic                                       m_valid,
  input  logic                                       m_ready,
  output logic [fnms_pkg::OUT_TDATA_BITS-1:0]        m_data,
  output logic                                       m_last,
  output logic                                       m_user
);

  localparam int SB = SAMPLE_BITS;
  localparam int SW = SB + 2;
  localparam int K  = SB + 4;
  localparam int RW = SB + 3;
  localparam longint unsigned RECIP_L = (64'd1 << K) / 64'd3;
  localparam logic [RW-1:0] RECIP = RW'(RECIP_L);
  // bias making any three-term sum non-negative
  localparam logic [SW-1:0] OFFS = SW'(3) << (SB - 1);
  localparam int OW = (SB < fnms_pkg::SMOOTH_BITS) ? SB : fnms_pkg::SMOOTH_BITS;

  logic adv;

  logic [SB-1:0] v_up;
  logic [SB-1:0] v_down;
  logic [SB-1:0] v_left;
  logic [SB-1:0] v_right;
  logic signed [SW-1:0] t_up;
  logic signed [SW-1:0] t_down;
  logic signed [SW-1:0] t_left;
  logic signed [SW-1:0] t_right;
  logic [3:0] mask;

  logic                 b0_v;
  logic signed [SW-1:0] b0_sum;
  logic                 b0_c3;
  logic                 b0_c4;
  fnms_pkg::meta_t      b0_meta;

  logic                 b1_v;
  logic [SW-1:0]        b1_u;
  logic [SB-1:0]        b1_shift;
  logic                 b1_c3;
  fnms_pkg::meta_t      b1_meta;

  logic                 b2_v;
  logic [SW+RW-1:0]     b2_prod;
  logic [SW-1:0]        b2_u;
  logic [SB-1:0]        b2_shift;
  logic                 b2_c3;
  fnms_pkg::meta_t      b2_meta;

  logic signed [SW-1:0] half;
  logic signed [SW-1:0] quarter;
  logic [SB-1:0]        q0;
  logic [SW-1:0]        three_q;
  logic [SW-1:0]        rem;
  logic [SB-1:0]        q;
  logic [SB-1:0]        mean;
  logic [fnms_pkg::SMOOTH_BITS-1:0] smoothed;

  always_comb begin
    adv     = !m_valid || m_ready;
    q_pop   = q_valid && adv;
    v_up    = q_vals[fnms_pkg::VAL_UP*SB +: SB];
    v_down  = q_vals[fnms_pkg::VAL_DOWN*SB +: SB];
    v_left  = q_vals[fnms_pkg::VAL_LEFT*SB +: SB];
    v_right = q_vals[fnms_pkg::VAL_RIGHT*SB +: SB];
    t_up    = q_meta.nbr.up    ? {{2{v_up[SB-1]}}, v_up}       : '0;
    t_down  = q_meta.nbr.down  ? {{2{v_down[SB-1]}}, v_down}   : '0;
    t_left  = q_meta.nbr.left  ? {{2{v_left[SB-1]}}, v_left}   : '0;
    t_right = q_meta.nbr.right ? {{2{v_right[SB-1]}}, v_right} : '0;
    mask    = q_meta.nbr;
    half    = b0_sum >>> 1;
    quarter = b0_sum >>> 2;
    // floor(u/3): estimate is exact or one low
    q0       = b2_prod[K +: SB];
    three_q  = SW'(q0) + (SW'(q0) << 1);
    rem      = b2_u - three_q;
    q        = (rem >= SW'(3)) ? q0 + SB'(1) : q0;
    mean     = b2_c3 ? {~q[SB-1], q[SB-2:0]} : b2_shift;
    smoothed = fnms_pkg::SMOOTH_BITS'(mean[OW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // neighbour count is 2, 3 or 4: odd parity means 3
      b0_sum   <= t_up + t_down + t_left + t_right;
      b0_c3    <= ^mask;
      b0_c4    <= &mask;
      b0_meta  <= q_meta;

      b1_u     <= b0_sum + OFFS;
      b1_shift <= b0_c4 ? quarter[SB-1:0] : half[SB-1:0];
      b1_c3    <= b0_c3;
      b1_meta  <= b0_meta;

      b2_prod  <= b1_u * RECIP;
      b2_u     <= b1_u;
      b2_shift <= b1_shift;
      b2_c3    <= b1_c3;
      b2_meta  <= b1_meta;

      m_data   <= fnms_pkg::OUT_TDATA_BITS'({b2_meta.col, b2_meta.row, smoothed});
      m_last   <= b2_meta.run_last;
      m_user   <= b2_meta.frame_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b0_v    <= 1'b0;
      b1_v    <= 1'b0;
      b2_v    <= 1'b0;
      m_valid <= 1'b0;
    end else if (adv) begin
      b0_v    <= q_valid;
      b1_v    <= b0_v;
      b2_v    <= b1_v;
      m_valid <= b2_v;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/four_neighbour_mean_smoother.sv =====
// Output is registered; a result passes the front reads, command queue and back pipeline first.
// Throughput: one sample per cycle while the command queue has room; the final sample of a
//   frame then holds s_axis_tready low while the last row is read out of the
//   line store (two read ports). Results lag the input by one row.
// Reset (rst, synchronous, active high): position to row 0 col 0, queue and pipeline emptied,
//   num_rows = num_cols = 2. Line store contents are not cleared.
`default_nettype none

module four_neighbour_mean_smoother #(
  parameter int SAMPLE_BITS = fnms_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_COLS    = fnms_pkg::MAX_COLS_DEF,
  parameter int QUEUE_DEPTH = fnms_pkg::QUEUE_DEPTH_DEF,
  localparam int IN_BITS    = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // configuration write port
  input  logic                                 cfg_we,
  input  logic [fnms_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [fnms_pkg::NROWS_BITS-1:0]      cfg_data,
  // sample input
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [IN_BITS-1:0]                   s_axis_tdata,  // sample
  // result output
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [fnms_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,  // smoothed, out_row, out_col
  output logic                                 m_axis_tlast,  // run_last
  output logic                                 m_axis_tuser   // frame_last
);

  localparam int LW   = $clog2(QUEUE_DEPTH + 1);
  localparam int QW   = fnms_pkg::META_BITS + fnms_pkg::NUM_NBRS * SAMPLE_BITS;
  localparam int VW   = fnms_pkg::NUM_NBRS * SAMPLE_BITS;
  localparam int CB   = fnms_pkg::COL_BITS;

  // Config is held as last row / last column indexes, already clamped to
  // the legal frame size so the front end only ever compares for equality.
  logic [fnms_pkg::ROW_BITS-1:0] last_row;
  logic [CB-1:0]                 last_col;
  logic [CB-1:0]                 cols_in;
  logic [CB-1:0]                 cols_lim;

  always_comb begin
    cols_in = cfg_data[CB-1:0];
    priority if (cols_in < CB'(2)) begin
      cols_lim = CB'(1);
    end else if (cols_in > CB'(MAX_COLS)) begin
      cols_lim = CB'(MAX_COLS - 1);
    end else begin
      cols_lim = cols_in - CB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_row <= fnms_pkg::ROW_BITS'(1);
      last_col <= CB'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        fnms_pkg::REG_NUM_ROWS: last_row <= fnms_pkg::rows_last(cfg_data);
        fnms_pkg::REG_NUM_COLS: last_col <= cols_lim;
        default:                last_row <= last_row;
      endcase
    end
  end

  // Front end: accepts samples, writes the line store and reads the up and
  // right neighbours of the element each sample completes.  Left comes from
  // a two-deep history of right-hand reads.  The sample that closes a frame
  // switches the front end into a drain walk over the last row.
  logic            q_push;
  fnms_pkg::meta_t f_meta;
  logic [VW-1:0]   f_vals;
  logic [LW-1:0]   q_level;

  fnms_front #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_COLS    (MAX_COLS),
    .DEPTH       (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .restart  (cfg_we),
    .last_row (last_row),
    .last_col (last_col),
    .s_valid  (s_axis_tvalid),
    .s_ready  (s_axis_tready),
    .s_sample (s_axis_tdata[SAMPLE_BITS-1:0]),
    .q_level  (q_level),
    .cmd_push (q_push),
    .cmd_meta (f_meta),
    .cmd_vals (f_vals)
  );

  // Command queue: front reserves a slot before each read, so it never
  // overflows and a read once issued is never held up by output back-pressure.
  logic            q_valid;
  logic            q_pop;
  logic [QW-1:0]   q_data;
  fnms_pkg::meta_t b_meta;
  logic [VW-1:0]   b_vals;

  fnms_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data ({f_meta, f_vals}),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data),
    .level     (q_level)
  );

  assign b_meta = q_data[QW-1 -: fnms_pkg::META_BITS];
  assign b_vals = q_data[VW-1:0];

  // Back end: neighbour sum, then floor divide by 2, 3 or 4.  Divide by 3
  // is a reciprocal multiply with one correction step; 2 and 4 are shifts.
  // The whole back pipeline advances together when the output slot frees.
  fnms_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_meta  (b_meta),
    .q_vals  (b_vals),
    .q_pop   (q_pop),
    .m_valid (m_axis_tvalid),
    .m_ready (m_axis_tready),
    .m_data  (m_axis_tdata),
    .m_last  (m_axis_tlast),
    .m_user  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // slot reservation in the front end must keep the queue from overflowing
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_level < LW'(QUEUE_DEPTH)))
    else $error("command queue overflow");

  // the frame's final element is always the last result of its transaction
  a_frame_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("frame_last without run_last");
`endif

endmodule

`default_nettype wire

// ===== tb/smoother_check.sv =====
`timescale 1ns / 1ps

// Watches the config port and both streams, keeps its own line buffer and
// frame position, and compares each result transaction against the oldest
// predicted point.
module smoother_check (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [fnms_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [fnms_pkg::NROWS_BITS-1:0]       cfg_data,
  input  logic                                  s_axis_tvalid,
  input  logic                                  s_axis_tready,
  input  logic [15:0]                           s_axis_tdata,   // sample
  input  logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  input  logic [fnms_pkg::OUT_TDATA_BITS-1:0]   m_axis_tdata,   // smoothed, out_row, out_col
  input  logic                                  m_axis_tlast,   // run_last
  input  logic                                  m_axis_tuser,   // frame_last
  output int                                    mismatches,
  output int                                    outstanding
);
  import fnms_pkg::*;

  localparam int BUF_COLS   = MAX_COLS_DEF;
  localparam int SAMPLE_W   = SAMPLE_BITS_DEF;
  localparam int PRINT_MAX  = 100;

  typedef struct {
    logic signed [SMOOTH_BITS-1:0] smoothed;
    logic [ROW_BITS-1:0]           row;
    logic [COL_BITS-1:0]           col;
    logic                          run_last;
    logic                          frame_last;
  } smoothed_point_t;

  logic signed [SAMPLE_W-1:0] line_buf [0:2][0:BUF_COLS-1];
  logic [NROWS_BITS-1:0]      rows_reg;
  logic [COL_BITS-1:0]        cols_reg;
  int unsigned                next_row;
  int unsigned                next_col;
  smoothed_point_t            pending_points[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic int unsigned active_rows();
    if (rows_reg < 2) return 2;
    if (rows_reg > ROWS_LIMIT) return ROWS_LIMIT;
    return rows_reg;
  endfunction

  function automatic int unsigned active_cols();
    if (cols_reg < 2) return 2;
    if (cols_reg > BUF_COLS) return BUF_COLS;
    return cols_reg;
  endfunction

  // floor mean of the in-bounds up/down/left/right neighbours
  function automatic smoothed_point_t mean_of_neighbours(input int unsigned row,
                                                         input int unsigned col,
                                                         input int unsigned rows,
                                                         input int unsigned cols,
                                                         input logic last_in_run);
    int sum;
    int cnt;
    int q;
    smoothed_point_t p;
    sum = 0;
    cnt = 0;
    if (row > 0) begin
      sum += line_buf[(row - 1) % 3][col];
      cnt++;
    end
    if (row + 1 < rows) begin
      sum += line_buf[(row + 1) % 3][col];
      cnt++;
    end
    if (col > 0) begin
      sum += line_buf[row % 3][col - 1];
      cnt++;
    end
    if (col + 1 < cols) begin
      sum += line_buf[row % 3][col + 1];
      cnt++;
    end
    q = sum / cnt;
    if ((sum % cnt) != 0 && sum < 0) q--;
    p.smoothed   = SMOOTH_BITS'(q);
    p.row        = ROW_BITS'(row);
    p.col        = COL_BITS'(col);
    p.run_last   = last_in_run;
    p.frame_last = (row + 1 == rows) && (col + 1 == cols);
    return p;
  endfunction

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= PRINT_MAX) $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic predict_sample(input logic signed [SAMPLE_W-1:0] value);
    int unsigned rows;
    int unsigned cols;
    int unsigned r;
    int unsigned c;
    int unsigned total;
    int unsigned k;
    bit          ends_frame;
    rows = active_rows();
    cols = active_cols();
    r    = next_row;
    c    = next_col;
    if (r >= rows || c >= cols) begin
      r = 0;
      c = 0;
    end
    line_buf[r % 3][c] = value;
    ends_frame = (r + 1 == rows) && (c + 1 == cols);
    total = ((r >= 1) ? 1 : 0) + (ends_frame ? cols : 0);
    k = 0;
    // one row behind: this sample completes the point above it
    if (r >= 1) begin
      pending_points.push_back(mean_of_neighbours(r - 1, c, rows, cols, k + 1 == total));
      k++;
    end
    // last sample of the frame flushes the whole bottom row
    if (ends_frame) begin
      for (int unsigned j = 0; j < cols; j++) begin
        pending_points.push_back(mean_of_neighbours(r, j, rows, cols, k + 1 == total));
        k++;
      end
    end
    c++;
    if (c >= cols) begin
      c = 0;
      r++;
      if (r >= rows) r = 0;
    end
    next_row = r;
    next_col = c;
  endtask

  task automatic check_result();
    smoothed_point_t want;
    smoothed_point_t got;
    got.smoothed   = m_axis_tdata[SMOOTH_BITS-1:0];
    got.row        = m_axis_tdata[SMOOTH_BITS +: ROW_BITS];
    got.col        = m_axis_tdata[SMOOTH_BITS + ROW_BITS +: COL_BITS];
    got.run_last   = m_axis_tlast;
    got.frame_last = m_axis_tuser;
    if (pending_points.size() == 0) begin
      report($sformatf("unexpected result row %0d col %0d", got.row, got.col));
    end else begin
      want = pending_points.pop_front();
      if (got.smoothed !== want.smoothed)
        report($sformatf("(%0d,%0d) smoothed %0d, want %0d",
                         want.row, want.col, got.smoothed, want.smoothed));
      if (got.row !== want.row)
        report($sformatf("out_row %0d, want %0d", got.row, want.row));
      if (got.col !== want.col)
        report($sformatf("out_col %0d, want %0d", got.col, want.col));
      if (got.run_last !== want.run_last)
        report($sformatf("(%0d,%0d) run_last %b, want %b",
                         want.row, want.col, got.run_last, want.run_last));
      if (got.frame_last !== want.frame_last)
        report($sformatf("(%0d,%0d) frame_last %b, want %b",
                         want.row, want.col, got.frame_last, want.frame_last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rows_reg = 2;
      cols_reg = 2;
      next_row = 0;
      next_col = 0;
      pending_points.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (cfg_we) begin
        if (cfg_index == REG_NUM_ROWS) rows_reg = cfg_data;
        else if (cfg_index == REG_NUM_COLS) cols_reg = cfg_data[COL_BITS-1:0];
        next_row = 0;
        next_col = 0;
      end
      if (s_axis_tvalid && s_axis_tready) predict_sample(s_axis_tdata[SAMPLE_W-1:0]);
    end
    outstanding = pending_points.size();
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import fnms_pkg::*;

  localparam int SAMPLE_COUNT  = 430;     // random part stops once this many were sent
  localparam int SETTLE_CYCLES = 12;      // longer than the pipeline, covers row-0 samples in flight
  localparam int CYCLE_LIMIT   = 400000;  // watchdog, far above the slowest legal run

  // receiver backpressure flavors
  typedef enum {FLOW_FULL, FLOW_COIN, FLOW_QUARTER, FLOW_MOSTLY} flow_mode_t;
  // random phase flavors
  typedef enum {PH_WIDE, PH_TALL, PH_CLAMPED, PH_SMALL} phase_kind_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       cfg_we;
  logic [CFG_INDEX_BITS-1:0]  cfg_index;
  logic [NROWS_BITS-1:0]      cfg_data;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [15:0]                s_axis_tdata;   // sample
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [OUT_TDATA_BITS-1:0]  m_axis_tdata;   // smoothed, out_row, out_col
  logic                       m_axis_tlast;   // run_last
  logic                       m_axis_tuser;   // frame_last

  int                         mismatches;
  int                         outstanding;

  // sender bookkeeping
  int unsigned                burst_left;
  int unsigned                samples_sent;
  // frame shape as the block sees it after clamping
  int unsigned                frame_rows;
  int unsigned                frame_cols;
  logic [NROWS_BITS-1:0]      rows_val;
  logic [NROWS_BITS-1:0]      cols_val;

  // receiver pattern state
  flow_mode_t                 flow_mode;
  int unsigned                flow_left;
  int unsigned                flow_phase;

  int unsigned                cycle_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  four_neighbour_mean_smoother dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  smoother_check mean_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Watchdog: a hung handshake or a lost result ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: switches to a random flavor whenever its countdown runs out, so long
  // stretches of full throughput alternate with coin-flip, one-in-four and
  // light stalls. Updated on the falling edge only.
  always @(negedge clk) begin
    if (flow_left == 0) begin
      flow_mode = flow_mode_t'($urandom_range(0, 3));
      flow_left = $urandom_range(30, 200);
    end else begin
      flow_left--;
    end
    flow_phase++;
    case (flow_mode)
      FLOW_FULL:    m_axis_tready <= 1'b1;
      FLOW_COIN:    m_axis_tready <= ($urandom_range(0, 1) == 1);
      FLOW_QUARTER: m_axis_tready <= (flow_phase % 4 == 0);
      default:      m_axis_tready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // Mostly random 16-bit values, with the two extremes and values near zero
  // mixed in so floor rounding of small negative sums gets exercised.
  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'(int'($urandom_range(0, 8)) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // One sample transaction. Bursts of random length; between bursts tvalid
  // drops for a random gap, and sometimes there is no gap at all.
  task automatic send_sample(input logic [15:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 16'($urandom);
        repeat (gap) @(negedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do begin
      @(posedge clk);
    end while (!(s_axis_tvalid && s_axis_tready));
    @(negedge clk);
    burst_left--;
    samples_sent++;
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_sample(random_sample());
  endtask

  // Holds off the sender until the checker has nothing left in flight, then
  // lets the pipeline empty out (samples in row 0 produce no result).
  task automatic wait_drained();
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register writes only while idle. Each write also restarts the frame.
  task automatic configure(input logic [NROWS_BITS-1:0] rows_data,
                           input logic [NROWS_BITS-1:0] cols_data,
                           input bit write_rows, input bit write_cols);
    s_axis_tvalid <= 1'b0;
    wait_drained();
    if (write_rows) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_NUM_ROWS;
      cfg_data  <= rows_data;
      rows_val   = rows_data;
      @(negedge clk);
    end
    if (write_cols) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_NUM_COLS;
      cfg_data  <= cols_data;
      cols_val   = cols_data;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    // clamp the same way the block does: rows 2..4096, cols 2..62
    frame_rows = (rows_val < 2) ? 2 : (rows_val > ROWS_LIMIT) ? ROWS_LIMIT : rows_val;
    frame_cols = (cols_val[COL_BITS-1:0] < 2) ? 2 :
                 (cols_val[COL_BITS-1:0] > MAX_COLS_DEF) ? MAX_COLS_DEF :
                 cols_val[COL_BITS-1:0];
  endtask

  // cols value with junk in the upper data bits now and then; the block
  // only keeps the low six
  function automatic logic [NROWS_BITS-1:0] cols_word(input int unsigned cols);
    if ($urandom_range(0, 3) == 0) return {7'($urandom), 6'(cols)};
    return NROWS_BITS'(cols);
  endfunction

  initial begin
    phase_kind_t   kind;
    int unsigned   pick;
    int unsigned   frames;
    int unsigned   frame_size;
    int unsigned   wr_mask;
    bit            broken_tail;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = REG_NUM_ROWS;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    burst_left    = 0;
    samples_sent  = 0;
    frame_rows    = 2;
    frame_cols    = 2;
    rows_val      = 2;
    cols_val      = 2;
    flow_left     = 0;
    flow_phase    = 0;
    cycle_count   = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // ---- directed ----
    // Reset shape is 2x2: full-scale extremes, all points are corners.
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);

    // Start another frame but abandon it after three samples: (0,0) comes
    // out as floor(-5/2) = -3, then a register write restarts the frame.
    send_sample(16'hFFFF);
    send_sample(16'hFFFE);
    send_sample(16'hFFFD);

    // Below-range writes clamp to 2x2; positive fraction rounds down.
    configure(NROWS_BITS'(1), NROWS_BITS'(0), 1'b1, 1'b1);
    send_sample(16'h0000);
    send_sample(16'h0001);
    send_sample(16'h0000);
    send_sample(16'h0000);

    // 3x3, cols written with garbage in the upper bits: edges, corners and
    // one interior point with all four neighbours.
    configure(NROWS_BITS'(3), 13'h1FC3, 1'b1, 1'b1);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0005);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'hFFFF);

    // ---- random ----
    while (samples_sent < SAMPLE_COUNT) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) kind = PH_WIDE;
      else if (pick == 1) kind = PH_TALL;
      else if (pick == 2) kind = PH_CLAMPED;
      else kind = PH_SMALL;
      broken_tail = ($urandom_range(0, 3) == 0);
      case (kind)
        PH_WIDE: begin
          // full line store width; 63 clamps to 62
          configure(NROWS_BITS'(2),
                    cols_word($urandom_range(0, 1) ? MAX_COLS_DEF : MAX_COLS_DEF + 1),
                    1'b1, 1'b1);
          frames = 1;
          broken_tail = 1'b0;
        end
        PH_TALL: begin
          // row count at and above the limit; only a partial frame is sent
          case ($urandom_range(0, 3))
            0:       rows_val = NROWS_BITS'(ROWS_LIMIT);
            1:       rows_val = NROWS_BITS'(ROWS_LIMIT + 1);
            2:       rows_val = '1;
            default: rows_val = NROWS_BITS'($urandom_range(ROWS_LIMIT, 8191));
          endcase
          configure(rows_val, cols_word($urandom_range(2, 5)), 1'b1, 1'b1);
          frames = 0;
          broken_tail = 1'b1;
        end
        PH_CLAMPED: begin
          configure(NROWS_BITS'($urandom_range(0, 1)), cols_word($urandom_range(0, 1)),
                    1'b1, 1'b1);
          frames = $urandom_range(1, 2);
        end
        default: begin
          // sometimes only one register is rewritten, the other keeps its value
          wr_mask = $urandom_range(1, 3);
          configure(NROWS_BITS'($urandom_range(2, 6)), cols_word($urandom_range(2, 8)),
                    wr_mask[0], wr_mask[1]);
          frames = $urandom_range(1, 3);
        end
      endcase
      frame_size = frame_rows * frame_cols;
      repeat (frames) send_random(frame_size);
      // abandoned frame: cut short by the next register write
      if (broken_tail) begin
        if (kind == PH_TALL) send_random($urandom_range(20, 60));
        else send_random($urandom_range(1, frame_size - 1));
      end
    end

    s_axis_tvalid <= 1'b0;
    wait_drained();

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== four_neighbour_mean_smoother.f =====
rtl/fnms_pkg.sv
rtl/fnms_front.sv
rtl/fnms_queue.sv
rtl/fnms_back.sv
rtl/four_neighbour_mean_smoother.sv
tb/smoother_check.sv
tb/testbench.sv
